// ===== hw/rtl/ppmp3_pkg.sv =====
package ppmp3_pkg;

    // Characters the parser recognizes.
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [2:0] {
        KIND_WIDTH  = 3'd0,
        KIND_HEIGHT = 3'd1,
        KIND_MAXVAL = 3'd2,
        KIND_SAMPLE = 3'd3,
        KIND_REPORT = 3'd4
    } token_kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_SIG     = 3'd1,
        ST_HDR_SHORT   = 3'd2,
        ST_NON_DIGIT   = 3'd3,
        ST_TOO_MANY    = 3'd4
    } status_code_t;

    typedef struct packed {
        token_kind_t  kind;
        logic [31:0]  value;
        status_code_t status;
        logic         last;
    } token_t;

endpackage

// ===== hw/rtl/ppmp3_limit.sv =====
module ppmp3_limit #(
    parameter int SAMPLE_INDEX_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [31:0]                  hdr_width,
    input  logic [31:0]                  hdr_height,
    output logic [SAMPLE_INDEX_BITS:0]   limit
);
    localparam int SIB = SAMPLE_INDEX_BITS;

    logic [63:0]    prod_reg;
    logic [SIB:0]   limit_reg;
    logic [SIB:0]   limit_next;
    logic [SIB:0]   span;
    logic [SIB+1:0] triple;
    logic           prod_over;

    // Sample limit is min(width * height * 3, 2^SIB), computed over two stages.
    always_comb
    begin
        span       = {1'b1, {SIB{1'b0}}};
        prod_over  = (prod_reg[63:SIB] != '0);
        triple     = ({2'b00, prod_reg[SIB-1:0]} << 1) + {2'b00, prod_reg[SIB-1:0]};
        if (prod_over || (triple >= {1'b0, span}))
        begin
            limit_next = span;
        end
        else
        begin
            limit_next = triple[SIB:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg  <= '0;
            limit_reg <= '0;
        end
        else
        begin
            prod_reg  <= hdr_width * hdr_height;
            limit_reg <= limit_next;
        end
    end

    assign limit = limit_reg;

endmodule

// ===== hw/rtl/ppmp3_parse.sv =====
module ppmp3_parse #(
    parameter int SAMPLE_INDEX_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [7:0]                    cur_byte,
    input  logic                          cur_eos,
    input  logic [SAMPLE_INDEX_BITS:0]    limit,
    output logic                          res_valid,
    output ppmp3_pkg::token_t             res,
    output logic [SAMPLE_INDEX_BITS-1:0]  res_index,
    output logic [31:0]                   hdr_width,
    output logic [31:0]                   hdr_height
);
    import ppmp3_pkg::*;

    localparam int SIB      = SAMPLE_INDEX_BITS;
    localparam int CNT_BITS = (SIB < 32) ? SIB + 1 : 32;

    typedef enum logic [2:0] {
        PH_SIG0,
        PH_SIG1,
        PH_SKIP,
        PH_BODY,
        PH_HALT
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                comment_reg, comment_next;
    logic                digits_reg, digits_next;
    logic [31:0]         acc_reg, acc_next;
    logic [1:0]          hidx_reg, hidx_next;
    logic [31:0]         width_reg, width_next;
    logic [31:0]         height_reg, height_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    logic                is_white;
    logic                is_digit;
    logic                finish;
    logic [SIB:0]        count_ext;

    always_comb
    begin
        phase_next   = phase_reg;
        comment_next = comment_reg;
        digits_next  = digits_reg;
        acc_next     = acc_reg;
        hidx_next    = hidx_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res.kind     = KIND_REPORT;
        res.value    = '0;
        res.status   = ST_OK;
        res.last     = 1'b0;
        res_index    = count_reg[SIB-1:0];
        finish       = 1'b0;
        count_ext    = (SIB+1)'(count_reg);
        is_white     = (cur_byte == CH_SPACE) || (cur_byte inside {[CH_TAB:CH_CR]});
        is_digit     = cur_byte inside {[CH_ZERO:CH_NINE]};

        if (cur_eos)
        begin
            res_valid    = (phase_reg != PH_HALT);
            res.value    = 32'(count_reg);
            res.status   = ((phase_reg == PH_BODY) && (hidx_reg == 2'd3)) ? ST_OK : ST_HDR_SHORT;
            res.last     = 1'b1;
            phase_next   = PH_SIG0;
            comment_next = 1'b0;
            digits_next  = 1'b0;
            acc_next     = '0;
            hidx_next    = '0;
            width_next   = '0;
            height_next  = '0;
            count_next   = '0;
        end
        else
        begin
            case (phase_reg)
                PH_SIG0, PH_SIG1:
                begin
                    if (cur_byte != ((phase_reg == PH_SIG0) ? CH_P : CH_THREE))
                    begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_SIG;
                        res.last   = 1'b1;
                        res_index  = '0;
                    end
                    else
                    begin
                        phase_next = (phase_reg == PH_SIG0) ? PH_SIG1 : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    if (comment_reg)
                    begin
                        if (cur_byte == CH_NEWLINE)
                        begin
                            comment_next = 1'b0;
                            finish       = digits_reg;
                        end
                    end
                    else if (cur_byte == CH_HASH)
                    begin
                        comment_next = 1'b1;
                    end
                    else if (is_white)
                    begin
                        finish = digits_reg;
                    end
                    else if (is_digit)
                    begin
                        acc_next    = (acc_reg << 3) + (acc_reg << 1) + 32'(cur_byte[3:0]);
                        digits_next = 1'b1;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_NON_DIGIT;
                    end
                end
                default:
                begin
                end
            endcase

            // A completed number becomes a header token, a sample or an overflow report.
            if (finish)
            begin
                acc_next    = '0;
                digits_next = 1'b0;
                res_valid   = 1'b1;
                if (hidx_reg != 2'd3)
                begin
                    res.kind  = token_kind_t'({1'b0, hidx_reg});
                    res.value = acc_reg;
                    res_index = '0;
                    hidx_next = hidx_reg + 2'd1;
                    if (hidx_reg == 2'd0)
                    begin
                        width_next = acc_reg;
                    end
                    if (hidx_reg == 2'd1)
                    begin
                        height_next = acc_reg;
                    end
                end
                else if (count_ext >= limit)
                begin
                    res.value  = {24'd0, acc_reg[7:0]};
                    res.status = ST_TOO_MANY;
                end
                else
                begin
                    res.kind   = KIND_SAMPLE;
                    res.value  = {24'd0, acc_reg[7:0]};
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIG0;
            comment_reg <= 1'b0;
            digits_reg  <= 1'b0;
            acc_reg     <= '0;
            hidx_reg    <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            count_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            digits_reg  <= digits_next;
            acc_reg     <= acc_next;
            hidx_reg    <= hidx_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            count_reg   <= count_next;
        end
    end

    assign hdr_width  = width_reg;
    assign hdr_height = height_reg;

endmodule

// ===== hw/rtl/ppm_p3_ascii_stream_parser.sv =====
// A word accepted into the input register is parsed between that register and the result
// register, and its result is taken from the result register by the consumer.
// Throughput: one word per cycle while the consumer does not hold a waiting result with
// out_stall; the sample limit comes from a two-stage multiplier.
// Reset: rst_n is asynchronous and active low; it empties both registers and returns the
// parser to waiting for the first signature byte with an empty header.
module ppm_p3_ascii_stream_parser #(
    parameter int SAMPLE_INDEX_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    input_byte,
    input  logic                          end_of_stream,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    token_kind,
    output logic [31:0]                   token_value,
    output logic [SAMPLE_INDEX_BITS-1:0]  sample_index,
    output logic [2:0]                    status_code,
    output logic                          is_last
);
    import ppmp3_pkg::*;

    localparam int SIB = SAMPLE_INDEX_BITS;

    // Input register: holds the word waiting to be parsed.
    logic           in_valid_reg;
    logic [7:0]     byte_reg;
    logic           eos_reg;

    // Result register.
    logic           out_valid_reg;
    token_t         out_tok_reg;
    logic [SIB-1:0] out_index_reg;

    logic           advance;
    logic           fire;
    logic           res_valid;
    token_t         res;
    logic [SIB-1:0] res_index;
    logic [31:0]    hdr_width;
    logic [31:0]    hdr_height;
    logic [SIB:0]   limit;

    // The parse stage moves whenever the result register is empty or being drained,
    // so a pending result blocks the next word from entering only while out_stall holds it.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= input_byte;
            eos_reg  <= end_of_stream;
        end
    end

    // The width and height registers feed the limit pipeline. At least four words
    // separate the height token from the first sample, so the limit has settled by then.
    ppmp3_limit #(
        .SAMPLE_INDEX_BITS (SIB)
    ) u_limit (
        .clk          (clk),
        .rst_n        (rst_n),
        .hdr_width    (hdr_width),
        .hdr_height   (hdr_height),
        .limit        (limit)
    );

    ppmp3_parse #(
        .SAMPLE_INDEX_BITS (SIB)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .cur_byte     (byte_reg),
        .cur_eos      (eos_reg),
        .limit        (limit),
        .res_valid    (res_valid),
        .res          (res),
        .res_index    (res_index),
        .hdr_width    (hdr_width),
        .hdr_height   (hdr_height)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_tok_reg   <= res;
            out_index_reg <= res_index;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = out_tok_reg.kind;
    assign token_value  = out_tok_reg.value;
    assign status_code  = out_tok_reg.status;
    assign is_last      = out_tok_reg.last;
    assign sample_index = out_index_reg;

    // The input side only backs up when a result is waiting and the consumer holds it.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // A bad signature always ends the stream.
    a_badsig_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_code == ST_BAD_SIG)) |-> is_last)
        else $error("bad signature report not marked last");

    // Only reports carry a nonzero status.
    a_status_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (token_kind != KIND_REPORT)) |-> (status_code == ST_OK))
        else $error("status on a non-report token");

    // A result appears only after a word was parsed in the previous cycle.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid_reg))
        else $error("result without a parsed word");

endmodule

// ===== sim/ppm_token_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the PPM parser. It keeps its own copy of the parser state,
// predicts the token that each accepted input word causes, and compares every accepted
// output word with the oldest prediction.
module ppm_token_checker #(
    parameter int IDX_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [7:0]          input_byte,
    input  logic                end_of_stream,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [2:0]          token_kind,
    input  logic [31:0]         token_value,
    input  logic [IDX_BITS-1:0] sample_index,
    input  logic [2:0]          status_code,
    input  logic                is_last,
    output int                  fail_count,
    output int                  pending_tokens
);

    import ppmp3_pkg::*;

    localparam logic [31:0] RADIX = 32'd10;

    typedef enum logic [2:0] {
        WAIT_P,
        WAIT_THREE,
        SKIP_SEP,
        IN_BODY,
        HALTED
    } parse_phase_t;

    typedef struct {
        token_kind_t         kind;
        logic [31:0]         value;
        logic [IDX_BITS-1:0] index;
        status_code_t        status;
        logic                last;
    } token_rec_t;

    token_rec_t        expected_tokens[$];
    int                errors = 0;

    parse_phase_t      phase;
    logic              in_comment;
    logic              have_digits;
    logic [31:0]       number_acc;
    logic [1:0]        header_count;
    logic [31:0]       width_val;
    logic [31:0]       height_val;
    logic [IDX_BITS:0] samples_seen;

    function automatic void clear_parser();
        phase        = WAIT_P;
        in_comment   = 1'b0;
        have_digits  = 1'b0;
        number_acc   = '0;
        header_count = '0;
        width_val    = '0;
        height_val   = '0;
        samples_seen = '0;
    endfunction

    function automatic void queue_token(input token_kind_t kind, input logic [31:0] value,
                                        input logic [63:0] idx, input status_code_t status,
                                        input logic last);
        token_rec_t rec;
        rec.kind   = kind;
        rec.value  = value;
        rec.index  = idx[IDX_BITS-1:0];
        rec.status = status;
        rec.last   = last;
        expected_tokens.push_back(rec);
    endfunction

    // Samples allowed: width*height*3, capped at the range of the index port.
    function automatic logic [63:0] sample_cap();
        logic [63:0] area;
        logic [63:0] span;
        area = {32'd0, width_val} * {32'd0, height_val};
        span = 64'd1 << IDX_BITS;
        if (area >= span)
            return span;
        if (area * 3 < span)
            return area * 3;
        return span;
    endfunction

    function automatic void close_number();
        logic [31:0] v;
        v           = number_acc;
        number_acc  = '0;
        have_digits = 1'b0;
        if (header_count == 2'd0) begin
            width_val = v;
            header_count++;
            queue_token(KIND_WIDTH, v, '0, ST_OK, 1'b0);
        end else if (header_count == 2'd1) begin
            height_val = v;
            header_count++;
            queue_token(KIND_HEIGHT, v, '0, ST_OK, 1'b0);
        end else if (header_count == 2'd2) begin
            header_count++;
            queue_token(KIND_MAXVAL, v, '0, ST_OK, 1'b0);
        end else if (64'(samples_seen) >= sample_cap()) begin
            queue_token(KIND_REPORT, {24'd0, v[7:0]}, 64'(samples_seen), ST_TOO_MANY, 1'b0);
        end else begin
            queue_token(KIND_SAMPLE, {24'd0, v[7:0]}, 64'(samples_seen), ST_OK, 1'b0);
            samples_seen++;
        end
    endfunction

    function automatic void scan_body(input logic [7:0] ch);
        if (in_comment) begin
            if (ch == CH_NEWLINE) begin
                in_comment = 1'b0;
                if (have_digits)
                    close_number();
            end
        end else if (ch == CH_HASH) begin
            in_comment = 1'b1;
        end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
            if (have_digits)
                close_number();
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            number_acc  = number_acc * RADIX + 32'(ch - CH_ZERO);
            have_digits = 1'b1;
        end else begin
            queue_token(KIND_REPORT, '0, 64'(samples_seen), ST_NON_DIGIT, 1'b0);
        end
    endfunction

    function automatic void predict_word(input logic [7:0] ch, input logic eos);
        parse_phase_t      was;
        logic [IDX_BITS:0] count;
        status_code_t      verdict;
        if (eos) begin
            was   = phase;
            count = samples_seen;
            if (phase == IN_BODY && header_count == 2'd3)
                verdict = ST_OK;
            else
                verdict = ST_HDR_SHORT;
            clear_parser();
            if (was != HALTED)
                queue_token(KIND_REPORT, 32'(count), 64'(count), verdict, 1'b1);
        end else begin
            case (phase)
                WAIT_P: begin
                    if (ch == CH_P) begin
                        phase = WAIT_THREE;
                    end else begin
                        phase = HALTED;
                        queue_token(KIND_REPORT, '0, '0, ST_BAD_SIG, 1'b1);
                    end
                end
                WAIT_THREE: begin
                    if (ch == CH_THREE) begin
                        phase = SKIP_SEP;
                    end else begin
                        phase = HALTED;
                        queue_token(KIND_REPORT, '0, '0, ST_BAD_SIG, 1'b1);
                    end
                end
                SKIP_SEP: phase = IN_BODY;
                IN_BODY:  scan_body(ch);
                default:  ;
            endcase
        end
    endfunction

    function automatic void check_token();
        token_rec_t want;
        if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: unexpected token: kind %0d value %0d index %0d status %0d last %0d",
                     $time, token_kind, token_value, sample_index, status_code, is_last);
            return;
        end
        want = expected_tokens.pop_front();
        if (token_kind !== want.kind) begin
            errors++;
            $display("%0t: token_kind expected %0d, actual %0d", $time, want.kind, token_kind);
        end
        if (token_value !== want.value) begin
            errors++;
            $display("%0t: token_value expected %0d, actual %0d",
                     $time, want.value, token_value);
        end
        if (sample_index !== want.index) begin
            errors++;
            $display("%0t: sample_index expected %0d, actual %0d",
                     $time, want.index, sample_index);
        end
        if (status_code !== want.status) begin
            errors++;
            $display("%0t: status_code expected %0d, actual %0d",
                     $time, want.status, status_code);
        end
        if (is_last !== want.last) begin
            errors++;
            $display("%0t: is_last expected %0d, actual %0d", $time, want.last, is_last);
        end
    endfunction

    // An output word can never belong to the input word taken at the same edge, so the
    // order of the two steps below does not matter.
    always @(posedge clk) begin
        if (!rst_n) begin
            clear_parser();
            expected_tokens.delete();
        end else begin
            if (out_valid && !out_stall)
                check_token();
            if (in_valid && !in_stall)
                predict_word(input_byte, end_of_stream);
        end
        fail_count     <= errors;
        pending_tokens <= expected_tokens.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import ppmp3_pkg::*;

    localparam int IDX_BITS     = 24;
    localparam int RANDOM_WORDS = 950;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;

    // Characters that the package does not name.
    localparam logic [7:0] CH_VTAB     = 8'h0B;
    localparam logic [7:0] CH_FORMFEED = 8'h0C;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_ALL_ONES = 8'hFF;
    localparam logic [7:0] CH_NUL      = 8'h00;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [7:0]          input_byte    = '0;
    logic                end_of_stream = 1'b0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [2:0]          token_kind;
    logic [31:0]         token_value;
    logic [IDX_BITS-1:0] sample_index;
    logic [2:0]          status_code;
    logic                is_last;

    int                  mismatch_count;
    int                  tokens_waiting;
    int                  cycle_count   = 0;

    // The receiver process starts its long hold-off once this is raised.
    logic                hold_request  = 1'b0;

    // Text of the file being built, and how many of its bytes the parser will skip
    // because they follow a bad signature.
    logic [7:0]          file_text[$];
    int                  ignored_bytes;
    int                  burst_words   = 0;

    ppm_p3_ascii_stream_parser #(
        .SAMPLE_INDEX_BITS(IDX_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .input_byte   (input_byte),
        .end_of_stream(end_of_stream),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_value  (token_value),
        .sample_index (sample_index),
        .status_code  (status_code),
        .is_last      (is_last)
    );

    ppm_token_checker #(
        .IDX_BITS(IDX_BITS)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .input_byte    (input_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .token_value   (token_value),
        .sample_index  (sample_index),
        .status_code   (status_code),
        .is_last       (is_last),
        .fail_count    (mismatch_count),
        .pending_tokens(tokens_waiting)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost token ends the run here.
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ppm_p3_ascii_stream_parser verification failed");
        $finish;
    end

    // Receiver side. Mostly short bursts of stall, with the occasional long one and the
    // occasional long stretch of no stall at all. Once the stimulus asks for it, the
    // receiver refuses everything through one long hold-off so that the parser backs up into
    // its input while the sender keeps offering words.
    initial begin
        int unsigned r;
        int unsigned len;
        logic        hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_request && !hold_done) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    out_stall <= 1'b0;
                    len = $urandom_range(1, 6);
                end else if (r < 63) begin
                    out_stall <= 1'b0;
                    len = $urandom_range(40, 120);
                end else if (r < 93) begin
                    out_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    len = $urandom_range(8, 40);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    // Idle cycles before the next input word: usually none or a few, sometimes many,
    // and now and then a burst of words sent back to back.
    function automatic int unsigned sender_gap();
        int unsigned r;
        if (burst_words > 0) begin
            burst_words--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_words = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one word and returns at the edge where it is taken. The payload holds
    // steady for as long as the parser stalls it.
    task automatic send_word(input logic [7:0] ch, input logic eos);
        int unsigned gap;
        gap = sender_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        input_byte    <= ch;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic void put(input logic [7:0] ch);
        file_text.push_back(ch);
    endfunction

    function automatic logic [7:0] pick_white();
        case ($urandom_range(0, 9))
            0:       return CH_TAB;
            1, 2:    return CH_NEWLINE;
            3:       return CH_VTAB;
            4:       return CH_FORMFEED;
            5:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // A byte that is neither a digit, whitespace, nor the comment mark.
    function automatic logic [7:0] pick_junk();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_HASH || b == CH_SPACE ||
               (b >= CH_TAB && b <= CH_CR));
        return b;
    endfunction

    // Comment text may hold any byte but a newline, which closes it.
    function automatic void put_comment();
        logic [7:0] b;
        put(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom);
            put(b == CH_NEWLINE ? CH_SPACE : b);
        end
        put(CH_NEWLINE);
    endfunction

    function automatic void put_spacing();
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1)
            put(pick_white());
        if ($urandom_range(0, 9) == 0)
            put_comment();
    endfunction

    // Writes a number in decimal and ends it. Values past 32 bits wrap in the parser.
    // Sometimes a stray byte sits right before the end, and sometimes the number runs
    // straight into a comment, whose closing newline then ends it.
    function automatic void put_number(input longint unsigned v);
        logic [7:0] digits[$];
        do begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        if ($urandom_range(0, 15) == 0)
            put(CH_ZERO);
        foreach (digits[i])
            put(digits[i]);
        if ($urandom_range(0, 19) == 0)
            put(pick_junk());
        if ($urandom_range(0, 9) == 0)
            put_comment();
        else
            put_spacing();
    endfunction

    function automatic void put_partial_number();
        repeat ($urandom_range(1, 3))
            put(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic longint unsigned pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 88)
            return 0;
        if (r < 95)
            return $urandom;
        return {$urandom, $urandom};
    endfunction

    function automatic longint unsigned pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 255);
        if (r < 95)
            return $urandom_range(256, 99999);
        return {$urandom, $urandom};
    endfunction

    function automatic void put_signature();
        put(CH_P);
        put(CH_THREE);
        put($urandom_range(0, 9) < 7 ? CH_NEWLINE : 8'($urandom));
    endfunction

    // A well-formed image with random content. Small images get their full pixel
    // array plus, now and then, a few samples too many or a short count.
    function automatic void make_image();
        longint unsigned w;
        longint unsigned h;
        longint unsigned total;
        put_signature();
        if ($urandom_range(0, 3) == 0)
            put_spacing();
        w = pick_dim();
        h = pick_dim();
        put_number(w);
        put_number(h);
        put_number($urandom_range(0, 1) ? 255 : $urandom_range(1, 65535));
        if (w <= 3 && h <= 3)
            total = w * h * 3;
        else
            total = $urandom_range(4, 12);
        if ($urandom_range(0, 9) < 3)
            total += $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0)
            total = $urandom_range(0, int'(total));
        repeat (total)
            put_number(pick_sample());
        case ($urandom_range(0, 9))
            0, 1:    put_partial_number();
            2: begin
                put(CH_HASH);
                put(8'($urandom_range(0, 9) + 8'h61));
            end
            default: ;
        endcase
    endfunction

    // Ends before the header is complete, possibly inside the signature.
    function automatic void make_short_header();
        case ($urandom_range(0, 9))
            0: ;
            1: put(CH_P);
            2: begin
                put(CH_P);
                put(CH_THREE);
            end
            default: begin
                put_signature();
                repeat ($urandom_range(0, 2))
                    put_number(pick_dim());
                if ($urandom_range(0, 1))
                    put_partial_number();
            end
        endcase
    endfunction

    function automatic void make_bad_signature();
        logic [7:0] b;
        if ($urandom_range(0, 1)) begin
            do
                b = 8'($urandom);
            while (b == CH_P);
            put(b);
        end else begin
            put(CH_P);
            do
                b = 8'($urandom);
            while (b == CH_THREE);
            put(b);
        end
        ignored_bytes = $urandom_range(0, 4);
        repeat (ignored_bytes)
            put(8'($urandom));
    endfunction

    function automatic void make_noise();
        if ($urandom_range(0, 1))
            put_signature();
        repeat ($urandom_range(4, 20))
            put(8'($urandom));
    endfunction

    initial begin
        int sent;
        int unsigned r;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words. End of stream straight after reset reports an incomplete
        // header with no samples.
        send_word(8'($urandom), 1'b1);

        // A bad second signature byte halts the parser; it ignores the next byte and
        // the end of stream then gives no report.
        send_word(CH_P, 1'b0);
        send_word(CH_NUL, 1'b0);
        send_word(CH_ALL_ONES, 1'b0);
        send_word(8'($urandom), 1'b1);

        // A bad first byte does the same.
        send_word(CH_NUL, 1'b0);
        send_word(CH_ALL_ONES, 1'b1);

        // A zero width leaves no room for samples. The height is ended by the newline
        // of a comment that interrupts it, a whitespace run emits nothing, a letter is
        // reported as a stray byte, and the one sample is reported as one too many.
        send_word(CH_P, 1'b0);
        send_word(CH_THREE, 1'b0);
        send_word(CH_ALL_ONES, 1'b0);
        send_word(CH_ZERO, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(CH_TAB, 1'b0);
        send_word(CH_ZERO + 8'd5, 1'b0);
        send_word(CH_HASH, 1'b0);
        send_word(CH_ALL_ONES, 1'b0);
        send_word(CH_NEWLINE, 1'b0);
        send_word(CH_NINE, 1'b0);
        send_word(CH_CR, 1'b0);
        send_word(CH_UPPER_A, 1'b0);
        send_word(CH_ZERO + 8'd4, 1'b0);
        send_word(CH_ZERO + 8'd2, 1'b0);
        send_word(CH_VTAB, 1'b0);
        send_word(CH_ALL_ONES, 1'b1);

        // Random files, most of them well formed. The long receiver hold-off is requested here
        // and begins once the receiver ends its current stretch, while the sender keeps going.
        hold_request = 1'b1;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            file_text.delete();
            ignored_bytes = 0;
            r = $urandom_range(0, 99);
            if (r < 70)
                make_image();
            else if (r < 80)
                make_short_header();
            else if (r < 90)
                make_bad_signature();
            else
                make_noise();
            foreach (file_text[i])
                send_word(file_text[i], 1'b0);
            send_word(8'($urandom), 1'b1);
            sent += file_text.size() + 1 - ignored_bytes;
        end
        in_valid <= 1'b0;

        // The count of waiting tokens is registered, so let the last word land first.
        @(posedge clk);
        while (tokens_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && tokens_waiting == 0)
            $display("ppm_p3_ascii_stream_parser verification clean");
        else
            $display("ppm_p3_ascii_stream_parser verification failed");
        $finish;
    end

endmodule
